FILE: design/jsrd_pkg.sv
`timescale 1ns / 1ps
// Package for the joystick stepper ramp drive: widths, types, command codes,
// register indexes, reset values. No dependencies.
package jsrd_pkg;

	localparam int JOY_W    = 12;
	localparam int PERIOD_W = 16;
	localparam int RAMP_W   = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	typedef logic [JOY_W-1:0]      joy_t;
	typedef logic [PERIOD_W-1:0]   period_t;
	typedef logic [RAMP_W-1:0]     ramp_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// register indexes
	localparam cfg_idx_t REG_START_PERIOD  = 3'd0;
	localparam cfg_idx_t REG_TARGET_PERIOD = 3'd1;
	localparam cfg_idx_t REG_PERIOD_DEC    = 3'd2;
	localparam cfg_idx_t REG_RAMP_INTERVAL = 3'd3;
	localparam cfg_idx_t REG_LOW_THRESH    = 3'd4;
	localparam cfg_idx_t REG_HIGH_THRESH   = 3'd5;

	// register reset values
	localparam period_t RST_START_PERIOD  = 16'd1000;
	localparam period_t RST_TARGET_PERIOD = 16'd700;
	localparam period_t RST_PERIOD_DEC    = 16'd10;
	localparam ramp_t   RST_RAMP_INTERVAL = 20'd50000;
	localparam joy_t    RST_LOW_THRESH    = 12'd1000;
	localparam joy_t    RST_HIGH_THRESH   = 12'd3000;

endpackage

FILE: design/jsrd_in_if.sv
`timescale 1ns / 1ps
// Request channel into the drive: tick or joystick sample.
// Depends on jsrd_pkg.
interface jsrd_in_if;
	import jsrd_pkg::*;

	logic valid;
	logic ready;
	logic cmd;
	joy_t joy_x;
	joy_t joy_y;

	modport source (output valid, cmd, joy_x, joy_y, input ready);
	modport sink   (input valid, cmd, joy_x, joy_y, output ready);
endinterface

FILE: design/jsrd_out_if.sv
`timescale 1ns / 1ps
// Result channel out of the drive: step pulses, flags and current period.
// Depends on jsrd_pkg.
interface jsrd_out_if;
	import jsrd_pkg::*;

	logic    valid;
	logic    ready;
	logic    step_right;
	logic    step_left;
	logic    heading_right;
	logic    heading_left;
	logic    run_right;
	logic    run_left;
	period_t period_now;

	modport source (output valid, step_right, step_left, heading_right, heading_left,
		run_right, run_left, period_now, input ready);
	modport sink   (input valid, step_right, step_left, heading_right, heading_left,
		run_right, run_left, period_now, output ready);
endinterface

FILE: design/jsrd_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel of the drive.
// Depends on jsrd_pkg.
interface jsrd_cfg_if;
	import jsrd_pkg::*;

	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/joystick_stepper_ramp_drive.sv
`timescale 1ns / 1ps
// Joystick stepper ramp drive: top level with decode, step timing and ramp.
// Depends on jsrd_pkg, jsrd_in_if, jsrd_out_if, jsrd_cfg_if.
//
// Channel  Dir  Payload                                          Request taken when
// in_ch    in   cmd, joy_x, joy_y                                valid && ready
// out_ch   out  step_right/left, heading_right/left,             valid && ready
//               run_right/left, period_now
// cfg_ch   in   index, data                                      valid && ready (always ready)
//
// One request per cycle sustained while out_ch takes results. A taken request sits in
// the input register; when it moves on, its state update is done and its result is
// loaded into the result register, which offers it on out_ch until it is handed off.
// A stalled out_ch holds the result register and the input register, and in_ch.ready
// drops only when both are full.
// arst_n clears flags, counters, configuration registers and valid bits to their
// reset values; no clearing pass is needed.
module joystick_stepper_ramp_drive (
	input  logic            clk,
	input  logic            arst_n,
	jsrd_in_if.sink         in_ch,
	jsrd_out_if.source      out_ch,
	jsrd_cfg_if.sink        cfg_ch
);
	import jsrd_pkg::*;

	// configuration registers
	period_t start_period_q;
	period_t target_period_q;
	period_t period_dec_q;
	ramp_t   ramp_interval_q;
	joy_t    low_thresh_q;
	joy_t    high_thresh_q;

	// drive state
	logic    heading_right_q, heading_left_q, run_right_q, run_left_q;
	period_t period_q;
	period_t period_cnt_q;
	ramp_t   ramp_cnt_q;
	logic    ramp_armed_q, ramp_due_q;

	// input register
	logic valid_s1;
	logic cmd_s1;
	joy_t joy_x_s1, joy_y_s1;

	// result register
	logic    out_valid_q;
	logic    step_right_q, step_left_q;
	period_t period_out_q;
	logic    heading_right_out_q, heading_left_out_q, run_right_out_q, run_left_out_q;

	logic advance;
	logic in_take;

	assign advance = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	// ---- register writes (write only while idle; the block does not enforce this) ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_period_q  <= RST_START_PERIOD;
			target_period_q <= RST_TARGET_PERIOD;
			period_dec_q    <= RST_PERIOD_DEC;
			ramp_interval_q <= RST_RAMP_INTERVAL;
			low_thresh_q    <= RST_LOW_THRESH;
			high_thresh_q   <= RST_HIGH_THRESH;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_START_PERIOD:  start_period_q  <= cfg_ch.data[PERIOD_W-1:0];
				REG_TARGET_PERIOD: target_period_q <= cfg_ch.data[PERIOD_W-1:0];
				REG_PERIOD_DEC:    period_dec_q    <= cfg_ch.data[PERIOD_W-1:0];
				REG_RAMP_INTERVAL: ramp_interval_q <= cfg_ch.data[RAMP_W-1:0];
				REG_LOW_THRESH:    low_thresh_q    <= cfg_ch.data[JOY_W-1:0];
				REG_HIGH_THRESH:   high_thresh_q   <= cfg_ch.data[JOY_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- sample decode ----
	logic centre;
	logic rr_d, lr_d, rd_d, ld_d;
	logic flags_change;

	always_comb begin
		rr_d = run_right_q;
		lr_d = run_left_q;
		rd_d = heading_right_q;
		ld_d = heading_left_q;
		centre = (joy_y_s1 > low_thresh_q) && (joy_y_s1 < high_thresh_q);
		if (centre) begin
			if (joy_x_s1 > high_thresh_q) begin
				// forward
				rr_d = 1'b1; lr_d = 1'b1; rd_d = 1'b0; ld_d = 1'b1;
			end else if (joy_x_s1 < low_thresh_q) begin
				// backward
				rr_d = 1'b1; lr_d = 1'b1; rd_d = 1'b1; ld_d = 1'b0;
			end else begin
				// stop, keep directions
				rr_d = 1'b0; lr_d = 1'b0;
			end
		end else if (joy_y_s1 > high_thresh_q) begin
			// rotate left
			rr_d = 1'b1; lr_d = 1'b1; rd_d = 1'b1; ld_d = 1'b1;
		end else if (joy_y_s1 < low_thresh_q) begin
			// rotate right
			rr_d = 1'b1; lr_d = 1'b1; rd_d = 1'b0; ld_d = 1'b0;
		end
		flags_change = (rr_d != run_right_q) || (lr_d != run_left_q) ||
			(rd_d != heading_right_q) || (ld_d != heading_left_q);
	end

	// ---- tick: ramp timer, period counter, ramp update ----
	ramp_t   ramp_inc;
	period_t period_inc;
	period_t period_gap;
	logic    ramp_hit;
	logic    boundary;
	logic    above_target;
	logic    dec_fits;
	ramp_t   ramp_cnt_nx;
	logic    ramp_armed_nx, ramp_due_nx;
	period_t period_nx, period_cnt_nx;

	always_comb begin
		ramp_inc     = ramp_cnt_q + 1'b1;
		ramp_hit     = ramp_inc >= ramp_interval_q;
		period_inc   = period_cnt_q + 1'b1;
		boundary     = period_inc >= period_q;
		above_target = period_q > target_period_q;
		period_gap   = period_q - target_period_q;
		dec_fits     = period_gap > period_dec_q;

		ramp_cnt_nx   = ramp_cnt_q;
		ramp_armed_nx = ramp_armed_q;
		ramp_due_nx   = ramp_due_q;
		period_nx     = period_q;
		period_cnt_nx = period_inc;

		// ramp timer runs first
		if (ramp_armed_q && !ramp_due_q) begin
			ramp_cnt_nx = ramp_inc;
			if (ramp_hit) begin
				ramp_due_nx   = 1'b1;
				ramp_armed_nx = 1'b0;
			end
		end

		if (boundary) begin
			period_cnt_nx = '0;
			if (ramp_due_nx) begin
				ramp_due_nx = 1'b0;
				if (above_target) begin
					period_nx     = dec_fits ? period_q - period_dec_q : target_period_q;
					ramp_cnt_nx   = '0;
					ramp_armed_nx = 1'b1;
				end
			end
		end
	end

	// ---- state and result register update ----
	logic work;
	assign work = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_right_q <= 1'b0;
			heading_left_q  <= 1'b0;
			run_right_q     <= 1'b0;
			run_left_q      <= 1'b0;
			period_q        <= RST_START_PERIOD;
			period_cnt_q    <= '0;
			ramp_cnt_q      <= '0;
			ramp_armed_q    <= 1'b0;
			ramp_due_q      <= 1'b0;
		end else if (work) begin
			if (cmd_s1 == CMD_SAMPLE) begin
				if (flags_change) begin
					run_right_q     <= rr_d;
					run_left_q      <= lr_d;
					heading_right_q <= rd_d;
					heading_left_q  <= ld_d;
					period_q        <= start_period_q;
					period_cnt_q    <= '0;
					ramp_cnt_q      <= '0;
					ramp_armed_q    <= 1'b1;
					ramp_due_q      <= 1'b0;
				end
			end else begin
				period_q     <= period_nx;
				period_cnt_q <= period_cnt_nx;
				ramp_cnt_q   <= ramp_cnt_nx;
				ramp_armed_q <= ramp_armed_nx;
				ramp_due_q   <= ramp_due_nx;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1   <= in_ch.cmd;
			joy_x_s1 <= in_ch.joy_x;
			joy_y_s1 <= in_ch.joy_y;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			if (cmd_s1 == CMD_SAMPLE) begin
				step_right_q        <= 1'b0;
				step_left_q         <= 1'b0;
				run_right_out_q     <= flags_change ? rr_d : run_right_q;
				run_left_out_q      <= flags_change ? lr_d : run_left_q;
				heading_right_out_q <= flags_change ? rd_d : heading_right_q;
				heading_left_out_q  <= flags_change ? ld_d : heading_left_q;
				period_out_q        <= flags_change ? start_period_q : period_q;
			end else begin
				// step pulses go to running motors at a period boundary
				step_right_q        <= boundary && run_right_q;
				step_left_q         <= boundary && run_left_q;
				run_right_out_q     <= run_right_q;
				run_left_out_q      <= run_left_q;
				heading_right_out_q <= heading_right_q;
				heading_left_out_q  <= heading_left_q;
				period_out_q        <= period_nx;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.step_right    = step_right_q;
	assign out_ch.step_left     = step_left_q;
	assign out_ch.heading_right = heading_right_out_q;
	assign out_ch.heading_left  = heading_left_out_q;
	assign out_ch.run_right     = run_right_out_q;
	assign out_ch.run_left      = run_left_out_q;
	assign out_ch.period_now    = period_out_q;

`ifndef SYNTHESIS
	// the ramp timer is either counting or waiting on a boundary, never both
	a_ramp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ramp_armed_q && ramp_due_q))
		else $error("ramp armed and due at once");

	// the period counter stays below a nonzero period
	a_period_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(period_cnt_q == '0) || (period_cnt_q < period_q))
		else $error("period counter past period");

	// a joystick sample never produces a step pulse
	a_sample_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(work && (cmd_s1 == CMD_SAMPLE)) |=> (!out_ch.step_right && !out_ch.step_left))
		else $error("step pulse on a sample");

	// a step pulse only goes to a motor reported as running
	a_step_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((!step_right_q || run_right_out_q) &&
			(!step_left_q || run_left_out_q)))
		else $error("step pulse on a stopped motor");
`endif

endmodule
